### src/lwbf_pkg.sv
// Shared types and constants for the logical-page write buffer.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lwbf_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_FLUSH = 2'd3
  } action_t;

  localparam logic [1:0]  ST_OK        = 2'd0;
  localparam logic [1:0]  ST_PAGE_OOR  = 2'd1;
  localparam logic [1:0]  ST_COUNT_BIG = 2'd2;

  localparam logic [3:0]  ERASE_MAX  = 4'd10;
  localparam logic [31:0] BLANK_WORD = 32'h0000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MEMRD,
    S_FL_LOAD,
    S_FL_WRITE,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic enqueue;
    logic scan_init;
    logic scan_step;
    logic hit_cap;
    logic mem_cap;
    logic fl_start;
    logic fl_load;
    logic fl_write;
    logic fl_next;
    logic fill_clear;
    logic resp_load;
  } lwbf_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t act;
    logic    bad;
    logic    fill_zero;
    logic    full_after;
    logic    scan_hit;
    logic    scan_last;
    logic    span_empty;
    logic    wr_last;
    logic    fl_last;
    logic    out_free;
  } lwbf_sts_t;

endpackage

`default_nettype wire

### src/lwbf_ctrl.sv
// Controller state machine for the logical-page write buffer.
// Depends on lwbf_pkg; drives the datapath through lwbf_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module lwbf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lwbf_pkg::lwbf_sts_t sts,
  output lwbf_pkg::lwbf_cmd_t    cmd
);
  import lwbf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.act == ACT_FLUSH) begin
          state_nxt = sts.fill_zero ? S_RESP : S_FL_LOAD;
        end else if (sts.bad) begin
          state_nxt = S_RESP;
        end else if (sts.act == ACT_READ) begin
          state_nxt = sts.fill_zero ? S_MEMRD : S_SCAN;
        end else begin
          state_nxt = sts.full_after ? S_FL_LOAD : S_RESP;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit)       state_nxt = S_RESP;
        else if (sts.scan_last) state_nxt = S_MEMRD;
      end
      S_MEMRD: state_nxt = S_RESP;
      S_FL_LOAD: begin
        if (sts.span_empty) begin
          if (sts.fl_last) state_nxt = S_RESP;
        end else begin
          state_nxt = S_FL_WRITE;
        end
      end
      S_FL_WRITE: begin
        if (sts.wr_last) state_nxt = sts.fl_last ? S_RESP : S_FL_LOAD;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        if (sts.act == ACT_FLUSH) begin
          cmd.fl_start = !sts.fill_zero;
        end else if (!sts.bad) begin
          if (sts.act == ACT_READ) begin
            cmd.scan_init = !sts.fill_zero;
          end else begin
            cmd.enqueue  = 1'b1;
            cmd.fl_start = sts.full_after;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_hit)        cmd.hit_cap   = 1'b1;
        else if (!sts.scan_last) cmd.scan_step = 1'b1;
      end
      S_MEMRD: cmd.mem_cap = 1'b1;
      S_FL_LOAD: begin
        if (sts.span_empty) begin
          cmd.fill_clear = sts.fl_last;
          cmd.fl_next    = !sts.fl_last;
        end else begin
          cmd.fl_load = 1'b1;
        end
      end
      S_FL_WRITE: begin
        cmd.fl_write = 1'b1;
        if (sts.wr_last) begin
          cmd.fill_clear = sts.fl_last;
          cmd.fl_next    = !sts.fl_last;
        end
      end
      S_RESP: cmd.resp_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/lwbf_datapath.sv
// Datapath: request registers, command buffer, page memory and result register.
// Depends on lwbf_pkg; steered by lwbf_ctrl through lwbf_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module lwbf_datapath #(
  parameter int NUM_PAGES = 128,
  parameter int BUF_DEPTH = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          in_action,
  input  wire logic [7:0]          in_page,
  input  wire logic [31:0]         in_write_word,
  input  wire logic [3:0]          in_erase_count,
  input  wire lwbf_pkg::lwbf_cmd_t cmd,
  output lwbf_pkg::lwbf_sts_t      sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_read_word,
  output logic [1:0]               out_status
);
  import lwbf_pkg::*;

  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam logic [8:0] NP9 = 9'(NUM_PAGES);

  // request registers
  action_t     act_r;
  logic [7:0]  page_r;
  logic [31:0] word_r;
  logic [3:0]  count_r;

  // command buffer
  logic [7:0]  buf_page_r [BUF_DEPTH];
  logic [31:0] buf_word_r [BUF_DEPTH];
  logic [3:0]  buf_span_r [BUF_DEPTH];
  logic [FW-1:0] fill_r;
  logic [IW-1:0] idx_r;

  // page memory with per-page written flags
  logic [31:0] mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] pvld_r;
  logic [31:0] rd_q;
  logic        rd_vld_q;

  logic [8:0]  ptr_r;
  logic [8:0]  end_r;
  logic [31:0] fl_word_r;
  logic [31:0] res_word_r;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [1:0]  out_status_r;

  logic [8:0]  sum_c;
  logic [8:0]  lo_c;
  logic [8:0]  hi_c;
  logic [8:0]  end_c;
  logic [1:0]  status_c;

  always_comb begin
    sum_c = {1'b0, page_r} + {5'b0, count_r};
    if (act_r == ACT_FLUSH) begin
      status_c = ST_OK;
    end else if ({1'b0, page_r} >= NP9) begin
      status_c = ST_PAGE_OOR;
    end else if (act_r == ACT_ERASE && count_r > ERASE_MAX) begin
      status_c = ST_COUNT_BIG;
    end else if (act_r == ACT_ERASE && (sum_c == 9'd0 || (sum_c - 9'd1) >= NP9)) begin
      status_c = ST_PAGE_OOR;
    end else begin
      status_c = ST_OK;
    end
  end

  // span of the entry under the shared index, clamped at the top page
  always_comb begin
    lo_c  = {1'b0, buf_page_r[idx_r]};
    hi_c  = lo_c + {5'b0, buf_span_r[idx_r]};
    end_c = (hi_c > NP9) ? NP9 : hi_c;
  end

  always_comb begin
    sts            = '0;
    sts.act        = act_r;
    sts.bad        = (status_c != ST_OK);
    sts.fill_zero  = (fill_r == '0);
    sts.full_after = (fill_r == FW'(BUF_DEPTH - 1));
    sts.scan_hit   = ({1'b0, page_r} >= lo_c) && ({1'b0, page_r} < hi_c);
    sts.scan_last  = (idx_r == '0);
    sts.span_empty = (end_c <= lo_c);
    sts.wr_last    = ((ptr_r + 9'd1) >= end_r);
    sts.fl_last    = (FW'(idx_r) == (fill_r - FW'(1)));
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= action_t'(in_action);
      page_r  <= in_page;
      word_r  <= in_write_word;
      count_r <= in_erase_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      buf_page_r[fill_r[IW-1:0]] <= page_r;
      buf_word_r[fill_r[IW-1:0]] <= (act_r == ACT_WRITE) ? word_r : BLANK_WORD;
      buf_span_r[fill_r[IW-1:0]] <= (act_r == ACT_WRITE) ? 4'd1 : count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.fill_clear) begin
      fill_r <= '0;
    end else if (cmd.enqueue) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  // one index walks the buffer: down for a lookup, up for a flush
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx_r <= IW'(fill_r - FW'(1));
    end else if (cmd.scan_step) begin
      idx_r <= idx_r - IW'(1);
    end else if (cmd.fl_start) begin
      idx_r <= '0;
    end else if (cmd.fl_next) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fl_load) begin
      ptr_r     <= lo_c;
      end_r     <= end_c;
      fl_word_r <= buf_word_r[idx_r];
    end else if (cmd.fl_write) begin
      ptr_r <= ptr_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fl_write) begin
      mem[ptr_r[PW-1:0]] <= fl_word_r;
    end
    rd_q <= mem[page_r[PW-1:0]];
  end

  // pages never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd.fl_write) pvld_r[ptr_r[PW-1:0]] <= 1'b1;
      rd_vld_q <= pvld_r[page_r[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_word_r <= BLANK_WORD;
    end else if (cmd.hit_cap) begin
      res_word_r <= buf_word_r[idx_r];
    end else if (cmd.mem_cap) begin
      res_word_r <= rd_vld_q ? rd_q : BLANK_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_word_r   <= res_word_r;
      out_status_r <= status_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_word = out_word_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

### src/lpn_write_buffer_with_flush.sv
// Top level of the logical-page store with its write-combining command buffer.
// Instantiates lwbf_ctrl and lwbf_datapath; depends on lwbf_pkg.
//
// One request is in work at a time. Writes and erases that do not fill the
// buffer, rejected requests and a flush of an empty buffer pass from the
// execute state straight to the result state. A read searches the buffered
// entries newest first, probing one entry a cycle; a miss then adds the
// registered page-memory read. A flush, requested or triggered by the request
// that fills the buffer, walks the entries oldest first, loading each entry
// and then writing its pages through the single memory write port. No
// clearing pass after reset: per-page written flags make untouched pages read
// as zero. A finished result sits in an output register; the next request is
// taken once that result is loaded.
`timescale 1ns / 1ps
`default_nettype none

module lpn_write_buffer_with_flush #(
  parameter int NUM_PAGES = 128,
  parameter int BUF_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_page,
  input  wire logic [31:0] in_write_word,
  input  wire logic [3:0]  in_erase_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_word,
  output logic [1:0]       out_status
);
  import lwbf_pkg::*;

  lwbf_cmd_t cmd;
  lwbf_sts_t sts;

  lwbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lwbf_datapath #(
    .NUM_PAGES (NUM_PAGES),
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_page        (in_page),
    .in_write_word  (in_write_word),
    .in_erase_count (in_erase_count),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_word  (out_read_word),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

### src/lwbf_checker.sv
// Port-level checks for lpn_write_buffer_with_flush, attached by bind.
// Sees the top-level ports only; takes status codes from lwbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwbf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_read_word,
  input wire logic [1:0]  out_status
);
  import lwbf_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_word) && $stable(out_status))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_COUNT_BIG)
    else $error("undefined status code");

  // rejected requests return no data
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_word == 32'd0)
    else $error("rejected request returned data");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

endmodule

bind lpn_write_buffer_with_flush lwbf_checker u_lwbf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_word (out_read_word),
  .out_status    (out_status)
);

`default_nettype wire

### test/tb_lpn_write_buffer_with_flush.sv
// Testbench for lpn_write_buffer_with_flush: directed and random requests under
// four idling patterns, each result checked against an in-bench page-store model.
// Depends on lwbf_pkg and the lpn_write_buffer_with_flush top level.
`timescale 1ns / 1ps

module tb_lpn_write_buffer_with_flush;
  import lwbf_pkg::*;

  localparam int NUM_PAGES = 128;
  localparam int BUF_DEPTH = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 400;

  typedef struct packed {
    logic [31:0] read_word;
    logic [1:0]  status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = 2'd0;
  logic [7:0]  in_page = 8'd0;
  logic [31:0] in_write_word = 32'd0;
  logic [3:0]  in_erase_count = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_word;
  logic [1:0]  out_status;

  // model of the store: page memory plus the pending command buffer
  logic [31:0] page_mem  [NUM_PAGES];
  logic [7:0]  pend_page [BUF_DEPTH];
  logic [31:0] pend_word [BUF_DEPTH];
  logic [3:0]  pend_span [BUF_DEPTH];
  int          pend_fill;

  result_t expected_results[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      errors = 0;
  int      results_checked = 0;
  int      requests_by_action[4];
  int      buffer_drains = 0;
  int      quiet_cycles = 0;

  lpn_write_buffer_with_flush #(
    .NUM_PAGES(NUM_PAGES),
    .BUF_DEPTH(BUF_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_page       (in_page),
    .in_write_word (in_write_word),
    .in_erase_count(in_erase_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_word (out_read_word),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void drain_pending();
    int lo;
    int hi;
    for (int k = 0; k < pend_fill; k++) begin
      lo = int'(pend_page[k]);
      hi = lo + int'(pend_span[k]);
      if (hi > NUM_PAGES) hi = NUM_PAGES;
      for (int p = lo; p < hi; p++) page_mem[p] = pend_word[k];
    end
    if (pend_fill > 0) buffer_drains++;
    pend_fill = 0;
  endfunction

  function automatic void queue_pending(logic [7:0] page, logic [31:0] word, logic [3:0] span);
    if (pend_fill < BUF_DEPTH) begin
      pend_page[pend_fill] = page;
      pend_word[pend_fill] = word;
      pend_span[pend_fill] = span;
      pend_fill++;
    end
    if (pend_fill >= BUF_DEPTH) drain_pending();
  endfunction

  function automatic logic [31:0] lookup_page(logic [7:0] page);
    int lo;
    // newest entry wins
    for (int k = pend_fill - 1; k >= 0; k--) begin
      lo = int'(pend_page[k]);
      if (int'(page) >= lo && int'(page) < lo + int'(pend_span[k])) return pend_word[k];
    end
    return page_mem[page];
  endfunction

  function automatic result_t store_response(action_t act, logic [7:0] page,
                                             logic [31:0] word, logic [3:0] count);
    result_t r;
    int last;
    r.read_word = 32'd0;
    r.status = ST_OK;
    last = int'(page) + int'(count) - 1;
    if (act == ACT_FLUSH) begin
      drain_pending();
    end else if (int'(page) >= NUM_PAGES) begin
      r.status = ST_PAGE_OOR;
    end else if (act == ACT_WRITE) begin
      queue_pending(page, word, 4'd1);
    end else if (act == ACT_READ) begin
      r.read_word = lookup_page(page);
    end else if (count > ERASE_MAX) begin
      r.status = ST_COUNT_BIG;
    end else if (last < 0 || last >= NUM_PAGES) begin
      r.status = ST_PAGE_OOR;
    end else begin
      queue_pending(page, BLANK_WORD, count);
    end
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus

  // Entered just after a falling edge; returns just after a falling edge.
  task automatic send_request(action_t act, logic [7:0] page, logic [31:0] word,
                              logic [3:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_page = page;
    in_write_word = word;
    in_erase_count = count;
    do @(posedge clk); while (!in_ready);
    expected_results.insert(expected_results.size(),
                            store_response(act, page, word, count));
    requests_by_action[act]++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_all_results();
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(ACT_WRITE, 8'd0,   32'hFFFF_FFFF, 4'd0);
    send_request(ACT_WRITE, 8'd127, 32'h0000_0000, 4'd15);
    send_request(ACT_WRITE, 8'd128, 32'h1234_5678, 4'd0);
    send_request(ACT_READ,  8'd0,   32'd0, 4'd0);
    send_request(ACT_READ,  8'd255, 32'd0, 4'd0);
    send_request(ACT_ERASE, 8'd0,   32'd0, 4'd0);   // last page below zero
    send_request(ACT_ERASE, 8'd10,  32'd0, 4'd0);   // empty span, covers nothing
    send_request(ACT_READ,  8'd10,  32'd0, 4'd0);
    send_request(ACT_ERASE, 8'd5,   32'd0, 4'd11);
    send_request(ACT_ERASE, 8'd200, 32'd0, 4'd15);  // range checked before count
    send_request(ACT_ERASE, 8'd121, 32'd0, 4'd8);   // last page just past the top
    send_request(ACT_ERASE, 8'd118, 32'd0, 4'd10);  // last page is the top page
    send_request(ACT_WRITE, 8'd0,   32'h5555_AAAA, 4'd0);
    send_request(ACT_READ,  8'd0,   32'd0, 4'd0);
    send_request(ACT_FLUSH, 8'd77,  32'd0, 4'd0);
    send_request(ACT_FLUSH, 8'd0,   32'd0, 4'd0);   // empty buffer
    send_request(ACT_READ,  8'd0,   32'd0, 4'd0);
    // fill the buffer to force an automatic drain
    send_request(ACT_ERASE, 8'd0,   32'd0, 4'd10);
    for (int i = 1; i < BUF_DEPTH; i++)
      send_request(ACT_WRITE, 8'(i), $urandom, 4'd0);
    send_request(ACT_READ,  8'd3,   32'd0, 4'd0);
  endtask

  task automatic send_random_request();
    action_t     act;
    logic [7:0]  page;
    logic [3:0]  count;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 35)      act = ACT_WRITE;
    else if (pick < 70) act = ACT_READ;
    else if (pick < 92) act = ACT_ERASE;
    else                act = ACT_FLUSH;
    // bias toward a few low pages so reads hit buffered entries, and toward the top pages
    pick = $urandom_range(99);
    if (pick < 40)      page = 8'($urandom_range(15));
    else if (pick < 50) page = 8'($urandom_range(NUM_PAGES - 1, NUM_PAGES - 18));
    else if (pick < 88) page = 8'($urandom_range(NUM_PAGES - 1));
    else                page = 8'($urandom_range(255));
    count = ($urandom_range(99) < 85) ? 4'($urandom_range(10)) : 4'($urandom_range(15));
    send_request(act, page, $urandom, count);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_request();
    // hold off until the block has answered everything
    wait_all_results();
  endtask

  // ------------------------------------------------------- result checking

  always @(negedge clk) out_ready = ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result read_word %h status %0d", $time,
                 out_read_word, out_status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_read_word !== want.read_word) begin
          $display("%0t: read_word mismatch, expected %h actual %h", $time,
                   want.read_word, out_read_word);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < NUM_PAGES; p++) page_mem[p] = 32'd0;
    pend_fill = 0;
    for (int a = 0; a < 4; a++) requests_by_action[a] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_all_results();
    test_random_phase(0, 0);
    test_random_phase(75, 0);
    test_random_phase(0, 75);
    test_random_phase(25, 25);

    wait_all_results();
    repeat (100) @(posedge clk);
    $display("Covered %0d writes, %0d reads, %0d erases, %0d flushes; %0d buffer drains.",
             requests_by_action[ACT_WRITE], requests_by_action[ACT_READ],
             requests_by_action[ACT_ERASE], requests_by_action[ACT_FLUSH], buffer_drains);
    $display("Checked %0d results with %0d mismatches.", results_checked, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
